### hdl/note_arpeggiator_defines.svh
// ----------------------------------------------------------------------------
// note_arpeggiator_defines
// Assertion macros used by narp_ctrl of the arpeggiator RTL.
// ----------------------------------------------------------------------------
`ifndef NOTE_ARPEGGIATOR_DEFINES_SVH
`define NOTE_ARPEGGIATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NARP_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("note_arpeggiator assertion failed");

// next-cycle implication, disabled during reset
`define NARP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("note_arpeggiator assertion failed");

`endif

### hdl/narp_pkg.sv
// ----------------------------------------------------------------------------
// narp_pkg
// Types, widths and codes of the note arpeggiator.
// ----------------------------------------------------------------------------
package narp_pkg;

   localparam int NOTE_SLOTS = 8;
   localparam int SLOT_W     = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int COUNT_W    = $clog2(NOTE_SLOTS + 1);

   localparam int OP_W       = 2;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int CHAN_W     = 4;
   localparam int TICK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CHANNEL   = 2'd1;

   localparam logic [TICK_W-1:0] TICK_INTERVAL_RST = 8'd6;
   localparam logic [CHAN_W-1:0] OUT_CHANNEL_RST   = 4'd0;

   localparam logic MSG_NOTE_OFF = 1'b0;
   localparam logic MSG_NOTE_ON  = 1'b1;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  vel;
   } note_entry_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] channel;
      logic [NOTE_W-1:0] pitch;
      logic [VEL_W-1:0]  level;
      logic              last;
   } msg_type;

   typedef struct packed {
      logic    load;
      logic    two;
      msg_type m0;
      msg_type m1;
   } emit_req_type;

endpackage

### hdl/narp_ram.sv
// ----------------------------------------------------------------------------
// narp_ram
// Held-note store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module narp_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [narp_pkg::SLOT_W-1:0]  wr_addr,
   input  narp_pkg::note_entry_type     wr_data,
   input  logic [narp_pkg::SLOT_W-1:0]  rd_addr,
   output narp_pkg::note_entry_type     rd_data
);
   import narp_pkg::*;

   note_entry_type mem [NOTE_SLOTS];
   note_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/narp_emit.sv
// ----------------------------------------------------------------------------
// narp_emit
// Output register plus one pending word; takes up to two messages at once.
// ----------------------------------------------------------------------------
module narp_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  narp_pkg::emit_req_type        emit_req,
   output logic                          emit_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_msg_kind,
   output logic [narp_pkg::CHAN_W-1:0]   rsp_channel,
   output logic [narp_pkg::NOTE_W-1:0]   rsp_pitch,
   output logic [narp_pkg::VEL_W-1:0]    rsp_level,
   output logic                          rsp_last
);
   import narp_pkg::*;

   logic    out_vld_ff, out_vld_in;
   msg_type out_ff, out_in;
   logic    pend_vld_ff, pend_vld_in;
   msg_type pend_ff, pend_in;
   logic    take;

   assign take       = out_vld_ff && !rsp_stall;
   assign emit_ready = !pend_vld_ff && (!out_vld_ff || !rsp_stall);

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      if (emit_req.load) begin
         out_vld_in  = 1'b1;
         out_in      = emit_req.m0;
         pend_vld_in = emit_req.two;
         pend_in     = emit_req.m1;
      end else if (take) begin
         if (pend_vld_ff) begin
            out_in      = pend_ff;
            pend_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_msg_kind = out_ff.kind;
   assign rsp_channel  = out_ff.channel;
   assign rsp_pitch    = out_ff.pitch;
   assign rsp_level    = out_ff.level;
   assign rsp_last     = out_ff.last;

endmodule

### hdl/narp_ctrl.sv
// ----------------------------------------------------------------------------
// narp_ctrl
// Sequencer: append, scan and close-gap on the note store, tick divider, step.
// ----------------------------------------------------------------------------
`include "note_arpeggiator_defines.svh"

module narp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [narp_pkg::OP_W-1:0]       req_op,
   input  logic [narp_pkg::NOTE_W-1:0]     req_note,
   input  logic [narp_pkg::VEL_W-1:0]      req_velocity,
   input  logic                            csr_valid,
   input  logic [narp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [narp_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            wr_en,
   output logic [narp_pkg::SLOT_W-1:0]     wr_addr,
   output narp_pkg::note_entry_type        wr_data,
   output logic [narp_pkg::SLOT_W-1:0]     rd_addr,
   input  narp_pkg::note_entry_type        rd_data,
   output narp_pkg::emit_req_type          emit_req,
   input  logic                            emit_ready
);
   import narp_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_STEP, S_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic [COUNT_W-1:0] next_index_ff, next_index_in;
   logic               sounding_ff, sounding_in;
   logic [NOTE_W-1:0]  sounding_pitch_ff, sounding_pitch_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [TICK_W-1:0]  tick_interval_ff, tick_interval_in;
   logic [CHAN_W-1:0]  out_channel_ff, out_channel_in;
   logic [NOTE_W-1:0]  target_ff, target_in;
   logic [COUNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [COUNT_W-1:0] sh_ptr_ff, sh_ptr_in;
   msg_type            msg0_ff, msg0_in;
   msg_type            msg1_ff, msg1_in;
   logic               two_ff, two_in;

   logic               accept;
   logic [TICK_W:0]    tick_sum;
   logic [COUNT_W-1:0] step_idx;
   logic [COUNT_W:0]   sh_next;
   logic [COUNT_W:0]   sh_next2;
   logic               hit;
   logic               start_remove;
   msg_type            on_msg;
   msg_type            off_msg;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign tick_sum  = {1'b0, tick_count_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign step_idx  = (next_index_ff >= held_count_ff) ? '0 : next_index_ff;
   assign sh_next   = {1'b0, sh_ptr_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign sh_next2  = sh_next + {{COUNT_W{1'b0}}, 1'b1};
   assign hit       = chk_vld_ff && (rd_data.note == target_ff);

   always_comb begin
      on_msg.kind     = MSG_NOTE_ON;
      on_msg.channel  = out_channel_ff;
      on_msg.pitch    = rd_data.note;
      on_msg.level    = rd_data.vel;
      on_msg.last     = 1'b1;
      off_msg.kind    = MSG_NOTE_OFF;
      off_msg.channel = out_channel_ff;
      off_msg.pitch   = sounding_pitch_ff;
      off_msg.level   = '0;
      off_msg.last    = 1'b1;
   end

   always_comb begin
      state_in          = state_ff;
      held_count_in     = held_count_ff;
      next_index_in     = next_index_ff;
      sounding_in       = sounding_ff;
      sounding_pitch_in = sounding_pitch_ff;
      tick_count_in     = tick_count_ff;
      tick_interval_in  = tick_interval_ff;
      out_channel_in    = out_channel_ff;
      target_in         = target_ff;
      rd_ptr_in         = rd_ptr_ff;
      chk_vld_in        = chk_vld_ff;
      sh_ptr_in         = sh_ptr_ff;
      msg0_in           = msg0_ff;
      msg1_in           = msg1_ff;
      two_in            = two_ff;
      wr_en             = 1'b0;
      wr_addr           = held_count_ff[SLOT_W-1:0];
      wr_data           = rd_data;
      rd_addr           = rd_ptr_ff[SLOT_W-1:0];
      emit_req.load     = 1'b0;
      emit_req.two      = two_ff;
      emit_req.m0       = msg0_ff;
      emit_req.m1       = msg1_ff;
      start_remove      = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_INTERVAL: tick_interval_in = csr_data[TICK_W-1:0];
            CSR_OUT_CHANNEL:   out_channel_in   = csr_data[CHAN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_NOTE_ON: begin
                     if (req_velocity == '0) begin
                        start_remove = 1'b1;
                     end else if (held_count_ff < COUNT_W'(NOTE_SLOTS)) begin
                        wr_en         = 1'b1;
                        wr_data.note  = req_note;
                        wr_data.vel   = req_velocity;
                        held_count_in = held_count_ff + 1'b1;
                     end
                  end
                  OP_NOTE_OFF: start_remove = 1'b1;
                  OP_TICK: begin
                     if (tick_sum >= {1'b0, tick_interval_ff}) begin
                        tick_count_in = '0;
                        if (held_count_ff != '0) begin
                           rd_ptr_in = step_idx;
                           rd_addr   = step_idx[SLOT_W-1:0];
                           state_in  = S_STEP;
                        end else if (sounding_ff) begin
                           msg0_in     = off_msg;
                           two_in      = 1'b0;
                           sounding_in = 1'b0;
                           state_in    = S_EMIT;
                        end
                     end else begin
                        tick_count_in = tick_sum[TICK_W-1:0];
                     end
                  end
                  default: ;
               endcase
               if (start_remove) begin
                  target_in  = req_note;
                  rd_ptr_in  = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end
         // read slot rd_ptr each cycle, compare the word read the cycle before
         S_SCAN: begin
            if (hit) begin
               // the read issued now fetches the slot just above the match
               sh_ptr_in = rd_ptr_ff - 1'b1;
               state_in  = S_SHIFT;
            end else if (rd_ptr_ff < held_count_ff) begin
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_vld_in = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         // move slot j+1 down to j, prefetch j+2
         S_SHIFT: begin
            chk_vld_in = 1'b0;
            if (sh_next < {1'b0, held_count_ff}) begin
               wr_en     = 1'b1;
               wr_addr   = sh_ptr_ff[SLOT_W-1:0];
               wr_data   = rd_data;
               rd_addr   = sh_next2[SLOT_W-1:0];
               sh_ptr_in = sh_next[COUNT_W-1:0];
            end else begin
               held_count_in = held_count_ff - 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_STEP: begin
            if (sounding_ff) begin
               msg0_in      = off_msg;
               msg0_in.last = 1'b0;
               two_in       = 1'b1;
            end else begin
               msg0_in = on_msg;
               two_in  = 1'b0;
            end
            msg1_in           = on_msg;
            sounding_in       = 1'b1;
            sounding_pitch_in = rd_data.note;
            next_index_in     = rd_ptr_ff + 1'b1;
            state_in          = S_EMIT;
         end
         S_EMIT: begin
            if (emit_ready) begin
               emit_req.load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         held_count_ff     <= '0;
         next_index_ff     <= '0;
         sounding_ff       <= 1'b0;
         sounding_pitch_ff <= '0;
         tick_count_ff     <= '0;
         tick_interval_ff  <= TICK_INTERVAL_RST;
         out_channel_ff    <= OUT_CHANNEL_RST;
         chk_vld_ff        <= 1'b0;
      end else begin
         state_ff          <= state_in;
         held_count_ff     <= held_count_in;
         next_index_ff     <= next_index_in;
         sounding_ff       <= sounding_in;
         sounding_pitch_ff <= sounding_pitch_in;
         tick_count_ff     <= tick_count_in;
         tick_interval_ff  <= tick_interval_in;
         out_channel_ff    <= out_channel_in;
         chk_vld_ff        <= chk_vld_in;
      end
      target_ff <= target_in;
      rd_ptr_ff <= rd_ptr_in;
      sh_ptr_ff <= sh_ptr_in;
      msg0_ff   <= msg0_in;
      msg1_ff   <= msg1_in;
      two_ff    <= two_in;
   end

   `NARP_ASSERT(a_count_range, clock, reset, 1'b1, held_count_ff <= COUNT_W'(NOTE_SLOTS))
   `NARP_ASSERT(a_next_range, clock, reset, 1'b1, next_index_ff <= COUNT_W'(NOTE_SLOTS))
   `NARP_ASSERT_NEXT(a_remove_dec, clock, reset,
      (state_ff == S_SHIFT) && !(sh_next < {1'b0, held_count_ff}),
      held_count_ff == $past(held_count_ff) - 1'b1)
   `NARP_ASSERT_NEXT(a_emit_hold, clock, reset,
      (state_ff == S_EMIT) && !emit_ready,
      (state_ff == S_EMIT) && $stable(msg0_ff) && $stable(two_ff))

endmodule

### hdl/note_arpeggiator.sv
// ----------------------------------------------------------------------------
// note_arpeggiator
// As-played MIDI arpeggiator: held-note list in a RAM, tick divider.
// ----------------------------------------------------------------------------
// Note-on append, ticks without a step and unused ops keep S_IDLE, no stall.
// Release: scan of one slot per cycle plus one per slot shifted down, set by
//   the single RAM read port. Step tick: S_IDLE reads, S_STEP builds and
//   S_EMIT loads the output register (a stop with an empty list skips S_STEP),
//   then one word per cycle if not stalled; input stalls while the load waits.
// Sync reset empties the list, clears counters, tick_interval 6, channel 0.
module note_arpeggiator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [narp_pkg::OP_W-1:0]       req_op,
   input  logic [narp_pkg::NOTE_W-1:0]     req_note,
   input  logic [narp_pkg::VEL_W-1:0]      req_velocity,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_msg_kind,
   output logic [narp_pkg::CHAN_W-1:0]     rsp_channel,
   output logic [narp_pkg::NOTE_W-1:0]     rsp_pitch,
   output logic [narp_pkg::VEL_W-1:0]      rsp_level,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [narp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [narp_pkg::CSR_DATA_W-1:0] csr_data
);
   import narp_pkg::*;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   note_entry_type     wr_data;
   logic [SLOT_W-1:0]  rd_addr;
   note_entry_type     rd_data;
   emit_req_type       emit_req;
   logic               emit_ready;

   assign csr_ready = 1'b1;

   narp_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   narp_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .emit_req     (emit_req),
      .emit_ready   (emit_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_msg_kind (rsp_msg_kind),
      .rsp_channel  (rsp_channel),
      .rsp_pitch    (rsp_pitch),
      .rsp_level    (rsp_level),
      .rsp_last     (rsp_last)
   );

   narp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_note     (req_note),
      .req_velocity (req_velocity),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .emit_req     (emit_req),
      .emit_ready   (emit_ready)
   );

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the note arpeggiator. A scoreboard class keeps a
// model of the held-note list, tick divider and register state, and predicts
// the note-off/note-on words for every accepted event. Directed events come
// first, then random phases across tick intervals and channels, with random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import narp_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 48;
   localparam int LONG_HOLD    = 400;

   class arp_scoreboard;
      logic [NOTE_W-1:0] slot_note[NOTE_SLOTS];
      logic [VEL_W-1:0]  slot_vel[NOTE_SLOTS];
      int                held;
      int                play_slot;
      bit                playing;
      logic [NOTE_W-1:0] voiced_pitch;
      int                ticks;
      int                interval;
      logic [CHAN_W-1:0] channel;
      msg_type           due_msgs[$];
      int                errors;

      function new();
         foreach (slot_note[i]) begin
            slot_note[i] = '0;
            slot_vel[i]  = '0;
         end
         held          = 0;
         play_slot     = 0;
         playing       = 0;
         voiced_pitch  = '0;
         ticks         = 0;
         interval      = int'(TICK_INTERVAL_RST);
         channel       = OUT_CHANNEL_RST;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TICK_INTERVAL: interval = int'(data);
            CSR_OUT_CHANNEL:   channel  = data[CHAN_W-1:0];
            default: ;
         endcase
      endfunction

      function msg_type make_msg(logic kind, logic [NOTE_W-1:0] pitch,
                                 logic [VEL_W-1:0] level);
         msg_type m;
         m.kind    = kind;
         m.channel = channel;
         m.pitch   = pitch;
         m.level   = level;
         m.last    = 1'b0;
         return m;
      endfunction

      // first match only; later slots shift down one
      function void release_key(logic [NOTE_W-1:0] key);
         for (int i = 0; i < held; i++) begin
            if (slot_note[i] == key) begin
               for (int j = i; j + 1 < held; j++) begin
                  slot_note[j] = slot_note[j+1];
                  slot_vel[j]  = slot_vel[j+1];
               end
               held--;
               return;
            end
         end
      endfunction

      function void take_event(logic [OP_W-1:0] op, logic [NOTE_W-1:0] key,
                               logic [VEL_W-1:0] vel);
         msg_type batch[$];
         msg_type m;
         case (op)
            OP_NOTE_ON: begin
               if (vel == 0) begin
                  release_key(key);
               end else if (held < NOTE_SLOTS) begin
                  slot_note[held] = key;
                  slot_vel[held]  = vel;
                  held++;
               end
            end
            OP_NOTE_OFF: release_key(key);
            OP_TICK: begin
               if (ticks + 1 >= interval) begin
                  ticks = 0;
                  if (held > 0) begin
                     if (playing) batch.push_back(make_msg(MSG_NOTE_OFF, voiced_pitch, '0));
                     // stale index after removals restarts from the top
                     if (play_slot >= held) play_slot = 0;
                     voiced_pitch = slot_note[play_slot];
                     batch.push_back(make_msg(MSG_NOTE_ON, voiced_pitch, slot_vel[play_slot]));
                     playing = 1;
                     play_slot++;
                  end else if (playing) begin
                     batch.push_back(make_msg(MSG_NOTE_OFF, voiced_pitch, '0));
                     playing = 0;
                  end
               end else begin
                  ticks = (ticks + 1) & 8'hff;
               end
            end
            default: ;
         endcase
         if (batch.size() > 0) begin
            m = batch.pop_back();
            m.last = 1'b1;
            batch.push_back(m);
         end
         foreach (batch[i]) due_msgs.push_back(batch[i]);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("mismatch @%0t: %s", $realtime, what);
      endtask

      task check_result(logic kind, logic [CHAN_W-1:0] chan, logic [NOTE_W-1:0] pitch,
                        logic [VEL_W-1:0] level, logic last);
         msg_type want;
         if (due_msgs.size() == 0) begin
            report($sformatf("unexpected word kind=%0d pitch=%0d", kind, pitch));
            return;
         end
         want = due_msgs.pop_front();
         if (kind !== want.kind)
            report($sformatf("msg_kind %0d, want %0d", kind, want.kind));
         if (chan !== want.channel)
            report($sformatf("channel %0d, want %0d", chan, want.channel));
         if (pitch !== want.pitch)
            report($sformatf("pitch %0d, want %0d", pitch, want.pitch));
         if (level !== want.level)
            report($sformatf("level %0d, want %0d", level, want.level));
         if (last !== want.last)
            report($sformatf("last %0d, want %0d", last, want.last));
      endtask

      function int pending();
         return due_msgs.size();
      endfunction

      task check_empty();
         if (due_msgs.size() != 0)
            report($sformatf("%0d words never arrived", due_msgs.size()));
      endtask
   endclass

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op       = '0;
   logic [NOTE_W-1:0]     req_note     = '0;
   logic [VEL_W-1:0]      req_velocity = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic                  rsp_msg_kind;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [NOTE_W-1:0]     rsp_pitch;
   logic [VEL_W-1:0]      rsp_level;
   logic                  rsp_last;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   arp_scoreboard sb = new();
   bit  calm      = 0;
   bit  hold_req  = 0;
   bit  gappy     = 0;
   int  pool_base = 0;

   note_arpeggiator dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) sb.take_event(req_op, req_note, req_velocity);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_msg_kind, rsp_channel, rsp_pitch, rsp_level, rsp_last);
      end
   end

   // output back-pressure: quiet stretches, stall bursts, one long hold-off
   initial begin
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (calm || $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   task send(logic [OP_W-1:0] op, logic [NOTE_W-1:0] key, logic [VEL_W-1:0] vel);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_note     <= key;
      req_velocity <= vel;
      do @(posedge clock); while (req_stall);
   endtask

   task pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait out every expected word plus the longest silent release scan
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_phase(int interval, int chan);
      write_reg(CSR_TICK_INTERVAL, interval[CSR_DATA_W-1:0]);
      write_reg(CSR_OUT_CHANNEL, chan[CSR_DATA_W-1:0]);
   endtask

   function logic [NOTE_W-1:0] pool_key();
      return NOTE_W'(pool_base + $urandom_range(0, 7));
   endfunction

   function logic [NOTE_W-1:0] any_note();
      return NOTE_W'($urandom_range(0, 127));
   endfunction

   function logic [VEL_W-1:0] any_vel(int lo);
      return VEL_W'($urandom_range(lo, 127));
   endfunction

   task random_events(int count, int tick_pct);
      int sent;
      int r;
      sent = 0;
      pool_base = $urandom_range(0, 120);
      while (sent < count) begin
         if (sent % 16 == 0) gappy = ($urandom_range(0, 2) != 0);
         if (!calm && gappy && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 15));
         r = $urandom_range(0, 99);
         sent++;
         if (r < tick_pct) begin
            send(OP_TICK, any_note(), any_vel(0));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 46)
               send(OP_NOTE_ON, pool_key(), any_vel(1));
            else if (r < 50)
               send(OP_NOTE_ON, any_note(), any_vel(1));
            else if (r < 60)
               send(OP_NOTE_ON, pool_key(), '0);
            else if (r < 92)
               send(OP_NOTE_OFF, pool_key(), any_vel(0));
            else if (r < 96)
               send(OP_NOTE_OFF, any_note(), any_vel(0));
            else begin
               send(OP_UNUSED, any_note(), any_vel(0));
               sent--;
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one step per tick
      set_phase(1, 5);
      send(OP_TICK, 7'd0, 7'd0);           // empty list, silent
      send(OP_NOTE_ON, 7'd0, 7'd127);
      send(OP_NOTE_ON, 7'd127, 7'd1);
      send(OP_NOTE_ON, 7'd60, 7'd64);
      send(OP_NOTE_ON, 7'd60, 7'd10);      // duplicate takes its own slot
      repeat (5) send(OP_TICK, 7'd127, 7'd127); // last one wraps
      send(OP_NOTE_OFF, 7'd60, 7'd127);    // velocity ignored
      send(OP_NOTE_OFF, 7'd99, 7'd0);      // not held
      send(OP_NOTE_ON, 7'd0, 7'd0);        // zero velocity releases sounding note
      send(OP_NOTE_OFF, 7'd127, 7'd0);
      send(OP_NOTE_OFF, 7'd60, 7'd0);
      send(OP_TICK, 7'd0, 7'd0);           // stop only
      send(OP_TICK, 7'd0, 7'd0);           // nothing
      for (int k = 0; k < 9; k++)          // ninth is dropped
         send(OP_NOTE_ON, 7'd1 << (k % 7), 7'd1 << (k % 7));
      send(OP_UNUSED, 7'd33, 7'd33);
      drain();

      set_phase(1, 15);
      random_events(130, 35);
      // fill the block against a long output hold-off
      hold_req = 1;
      gappy = 0;
      for (int k = 0; k < 80; k++) begin
         if (k % 5 == 0) send(OP_NOTE_ON, any_note(), any_vel(1));
         else send(OP_TICK, any_note(), any_vel(0));
      end
      drain();

      set_phase(255, 0);
      random_events(320, 85);
      drain();
      set_phase(2, 7);                     // count above new interval
      random_events(130, 35);
      drain();
      set_phase(4, 10);
      random_events(130, 40);
      drain();
      set_phase(3, 5);
      random_events(130, 35);
      drain();
      set_phase(6, 1);
      random_events(130, 45);
      drain();
      set_phase($urandom_range(1, 8), $urandom_range(0, 15));
      random_events(130, 35);
      drain();

      calm = 1;
      set_phase(2, 15);
      random_events(150, 35);
      drain();

      sb.check_empty();
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
